// ===== rtl/bra_pkg.sv =====
// Shared widths, register indexes and item types of the beat rate monitor.
`default_nettype none

package bra_pkg;

  localparam int TS_W        = 63;
  localparam int TAG_W       = 32;
  localparam int BEAT_W      = 48;
  localparam int SLOT_W      = 16;
  localparam int RATE_W      = 48;
  localparam int RATE_FRAC_W = 16;
  localparam int WLEN_W      = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Rate multiplicand: beat count plus one.
  localparam int M_W  = BEAT_W + 1;
  localparam int NS_W = 30;
  localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

  localparam int WINDOW_MAX_DEF    = 64;
  localparam int INTERVAL_BITS_DEF = 40;

  localparam logic [WLEN_W-1:0] WLEN_RESET  = 7'd16;
  localparam logic [SLOT_W-1:0] DEPTH_RESET = 16'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_DEPTH     = 8'd1;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [BEAT_W-1:0] BEAT_MAX = {BEAT_W{1'b1}};

  typedef struct packed {
    logic        [TS_W-1:0]  timestamp;
    logic signed [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic        [BEAT_W-1:0] beat_number;
    logic signed [TAG_W-1:0]  tag_out;
    logic        [TS_W-1:0]   beat_time;
    logic        [SLOT_W-1:0] log_slot;
    logic        [RATE_W-1:0] last_rate;
    logic        [RATE_W-1:0] mean_rate;
    logic        [RATE_W-1:0] total_rate;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [RATE_W-1:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bra_div.sv =====
// Shared rate unit: (m * 1e9 * 2^16) / den, one quotient bit per cycle, saturating.
`default_nettype none

module bra_div
  import bra_pkg::*;
#(
  parameter int DEN_W = TS_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [M_W-1:0]   m,
  input  wire logic [DEN_W-1:0] den,
  output div_rsp_t              rsp
);

  localparam int LO_W    = RATE_W - RATE_FRAC_W;
  localparam int PROD_W  = M_W + NS_W;
  localparam int MUL_P_W = LO_W + NS_W;
  localparam int NHI_W   = PROD_W - LO_W;
  localparam int CNT_W   = $clog2(RATE_W + 1);

  typedef enum logic [4:0] {
    D_IDLE   = 5'b00001,
    D_MUL_LO = 5'b00010,
    D_MUL_HI = 5'b00100,
    D_CHECK  = 5'b01000,
    D_ITER   = 5'b10000
  } dstate_t;

  dstate_t            state_r, state_nxt;
  logic [M_W-1:0]     m_r, m_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [RATE_W-1:0]  qn_r, qn_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic               sat_r, sat_nxt;

  logic [LO_W-1:0]    mul_a;
  logic [MUL_P_W-1:0] mul_p;
  logic [DEN_W-1:0]   nhi;
  logic [DEN_W:0]     rs;
  logic [DEN_W:0]     rs_diff;
  logic               ge;

  // One multiplier, used for the low then the high part of m.
  assign mul_a = (state_r == D_MUL_LO) ? m_r[LO_W-1:0] : LO_W'(m_r[M_W-1:LO_W]);
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(NS_PER_S);

  assign nhi     = DEN_W'(prod_r[PROD_W-1:LO_W]);
  assign rs      = {rem_r, qn_r[RATE_W-1]};
  assign rs_diff = rs - {1'b0, den_r};
  assign ge      = rs >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    den_nxt   = den_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    qn_nxt    = qn_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    sat_nxt   = sat_r;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          m_nxt     = m;
          den_nxt   = den;
          state_nxt = D_MUL_LO;
        end
      end
      D_MUL_LO: begin
        prod_nxt  = PROD_W'(mul_p);
        state_nxt = D_MUL_HI;
      end
      D_MUL_HI: begin
        prod_nxt  = prod_r + (PROD_W'(mul_p) << LO_W);
        state_nxt = D_CHECK;
      end
      D_CHECK: begin
        // Quotient reaches 2^48 exactly when the upper numerator part reaches den.
        if (nhi >= den_r) begin
          sat_nxt   = 1'b1;
          qn_nxt    = RATE_MAX;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          sat_nxt   = 1'b0;
          rem_nxt   = nhi;
          qn_nxt    = {prod_r[LO_W-1:0], {RATE_FRAC_W{1'b0}}};
          cnt_nxt   = CNT_W'(RATE_W);
          state_nxt = D_ITER;
        end
      end
      D_ITER: begin
        rem_nxt = ge ? rs_diff[DEN_W-1:0] : rs[DEN_W-1:0];
        qn_nxt  = {qn_r[RATE_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    m_r    <= m_nxt;
    den_r  <= den_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    qn_r   <= qn_nxt;
    cnt_r  <= cnt_nxt;
    sat_r  <= sat_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.q    = qn_r;

endmodule

`default_nettype wire

// ===== rtl/beat_rate_monitor.sv =====
// Beat rate monitor top level: beat sequencer, window store and rate unit.
//
// Each word on the in_ channel is one beat: a nanosecond timestamp and a tag.
// For each beat the block returns one word on the out_ channel: the count of
// earlier beats, the tag and time, the log slot, and the instant, window and
// global rates in unsigned Q32.16 beats per second, plus a saturation flag.
// in_ready is high only while no beat is being worked on. A beat passes three
// setup steps, then three quotients through the one shared divider, each
// made of a start, a two-step multiply, a range check, 48 one-bit steps and
// the handoff. The next beat is taken only once the result is handed on. A
// quotient that saturates ends at its range check. The first beat after reset
// produces zero rates and skips the quotients.
// The result sits in an output register; the next beat is taken while it
// waits. A result that finds the output register still full stalls the
// sequencer until out_ready takes the older word.
// The cfg_ port is always ready; index 0 writes window_length (and restarts
// the window), index 1 writes log_depth. Write it only while idle.
// Reset restores window_length 16, log_depth 1024 and clears all beat history.
`default_nettype none

module beat_rate_monitor
  import bra_pkg::*;
#(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = INTERVAL_BITS + AW;
  localparam int DEN_W = (SUM_W > TS_W) ? SUM_W : TS_W;
  localparam logic [INTERVAL_BITS-1:0] IV_MAX = {INTERVAL_BITS{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PREP     = 7'b0000010,
    S_SUM      = 7'b0000100,
    S_SPAN     = 7'b0001000,
    S_DIV_GO   = 7'b0010000,
    S_DIV_WAIT = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    DIV_INST = 2'd0,
    DIV_WIN  = 2'd1,
    DIV_GLOB = 2'd2
  } div_sel_t;

  state_t                   state_r, state_nxt;
  div_sel_t                 div_sel_r, div_sel_nxt;
  logic [WLEN_W-1:0]        wlen_r, wlen_nxt;
  logic [SLOT_W-1:0]        depth_r, depth_nxt;
  logic                     started_r, started_nxt;
  logic [TS_W-1:0]          first_time_r, first_time_nxt;
  logic [TS_W-1:0]          last_time_r, last_time_nxt;
  logic [BEAT_W-1:0]        beat_count_r, beat_count_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic                     full_r, full_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SLOT_W-1:0]        slot_ptr_r, slot_ptr_nxt;
  logic [TS_W-1:0]          ts_r, ts_nxt;
  logic signed [TAG_W-1:0]  tag_r, tag_nxt;
  logic [INTERVAL_BITS-1:0] iv_r, iv_nxt;
  logic [TS_W-1:0]          span_r, span_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  out_item_t                rec_r, rec_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [CNT_W-1:0]         len_eff;
  logic [SLOT_W-1:0]        depth_eff;
  logic [SLOT_W-1:0]        slot_cur;
  logic [SLOT_W:0]          slot_inc;
  logic                     pos_wrap;
  logic [CNT_W-1:0]         pos_inc;
  logic [TS_W-1:0]          ts_diff;
  logic [AW-1:0]            ram_raddr;
  logic                     ram_we;
  logic [INTERVAL_BITS-1:0] ram_rdata;

  logic                     div_start;
  logic [M_W-1:0]           div_m;
  logic [DEN_W-1:0]         div_den;
  div_rsp_t                 div_rsp;

  assign len_eff = (wlen_r == '0) ? CNT_W'(1) :
                   (32'(wlen_r) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(wlen_r);
  assign depth_eff = (depth_r == '0) ? SLOT_W'(1) : depth_r;
  assign slot_cur  = (slot_ptr_r >= depth_eff) ? '0 : slot_ptr_r;
  assign slot_inc  = {1'b0, slot_cur} + 1'b1;
  assign pos_wrap  = CNT_W'(pos_r) >= len_eff;
  assign pos_inc   = CNT_W'(pos_r) + 1'b1;
  assign ts_diff   = ts_r - last_time_r;

  // Read the entry about to be replaced; data lands for the sum step.
  assign ram_raddr = pos_wrap ? '0 : pos_r;
  assign ram_we    = (state_r == S_SUM);

  bra_ram #(
    .WIDTH (INTERVAL_BITS),
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (iv_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign div_start = (state_r == S_DIV_GO);

  always_comb begin
    case (div_sel_r)
      DIV_INST: begin
        div_m   = M_W'(1);
        div_den = DEN_W'(iv_r);
      end
      DIV_WIN: begin
        div_m   = M_W'(n_r);
        div_den = (sum_r == '0) ? DEN_W'(1) : DEN_W'(sum_r);
      end
      default: begin
        div_m   = M_W'(beat_count_r) + 1'b1;
        div_den = DEN_W'(span_r);
      end
    endcase
  end

  bra_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .m     (div_m),
    .den   (div_den),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    div_sel_nxt    = div_sel_r;
    wlen_nxt       = wlen_r;
    depth_nxt      = depth_r;
    started_nxt    = started_r;
    first_time_nxt = first_time_r;
    last_time_nxt  = last_time_r;
    beat_count_nxt = beat_count_r;
    pos_nxt        = pos_r;
    full_nxt       = full_r;
    sum_nxt        = sum_r;
    slot_ptr_nxt   = slot_ptr_r;
    ts_nxt         = ts_r;
    tag_nxt        = tag_r;
    iv_nxt         = iv_r;
    span_nxt       = span_r;
    n_nxt          = n_r;
    rec_nxt        = rec_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ts_nxt    = in_data.timestamp;
          tag_nxt   = in_data.tag;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        rec_nxt.beat_number = beat_count_r;
        rec_nxt.tag_out     = tag_r;
        rec_nxt.beat_time   = ts_r;
        rec_nxt.log_slot    = slot_cur;
        rec_nxt.last_rate   = '0;
        rec_nxt.mean_rate   = '0;
        rec_nxt.total_rate  = '0;
        rec_nxt.saturated   = 1'b0;
        last_time_nxt       = ts_r;
        if (!started_r) begin
          started_nxt    = 1'b1;
          first_time_nxt = ts_r;
          state_nxt      = S_DONE;
        end else begin
          // Clamp backward, zero and oversized intervals.
          if (ts_r <= last_time_r) begin
            iv_nxt            = INTERVAL_BITS'(1);
            rec_nxt.saturated = 1'b1;
          end else if (ts_diff > TS_W'(IV_MAX)) begin
            iv_nxt            = IV_MAX;
            rec_nxt.saturated = 1'b1;
          end else begin
            iv_nxt = ts_diff[INTERVAL_BITS-1:0];
          end
          if (pos_wrap) begin
            pos_nxt  = '0;
            full_nxt = 1'b1;
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = sum_r - (full_r ? SUM_W'(ram_rdata) : '0) + SUM_W'(iv_r);
        n_nxt   = full_r ? len_eff : pos_inc;
        if (pos_inc >= len_eff) begin
          pos_nxt  = '0;
          full_nxt = 1'b1;
        end else begin
          pos_nxt = pos_inc[AW-1:0];
        end
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (ts_r <= first_time_r) begin
          span_nxt          = TS_W'(1);
          rec_nxt.saturated = 1'b1;
        end else begin
          span_nxt = ts_r - first_time_r;
        end
        div_sel_nxt = DIV_INST;
        state_nxt   = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          rec_nxt.saturated = rec_r.saturated | div_rsp.sat;
          case (div_sel_r)
            DIV_INST: begin
              rec_nxt.last_rate = div_rsp.q;
              div_sel_nxt       = DIV_WIN;
              state_nxt         = S_DIV_GO;
            end
            DIV_WIN: begin
              rec_nxt.mean_rate = div_rsp.q;
              div_sel_nxt       = DIV_GLOB;
              state_nxt         = S_DIV_GO;
            end
            default: begin
              rec_nxt.total_rate = div_rsp.q;
              state_nxt          = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        // Hold until the output register is free, then advance the counters.
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = rec_r;
          out_valid_nxt = 1'b1;
          if (beat_count_r != BEAT_MAX) begin
            beat_count_nxt = beat_count_r + 1'b1;
          end
          slot_ptr_nxt = (slot_inc >= {1'b0, depth_eff}) ? '0 : slot_inc[SLOT_W-1:0];
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: begin
          wlen_nxt = cfg_data[WLEN_W-1:0];
          pos_nxt  = '0;
          full_nxt = 1'b0;
          sum_nxt  = '0;
        end
        REG_LOG_DEPTH: begin
          depth_nxt = cfg_data[SLOT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_sel_r    <= DIV_INST;
      wlen_r       <= WLEN_RESET;
      depth_r      <= DEPTH_RESET;
      started_r    <= 1'b0;
      first_time_r <= '0;
      last_time_r  <= '0;
      beat_count_r <= '0;
      pos_r        <= '0;
      full_r       <= 1'b0;
      sum_r        <= '0;
      slot_ptr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      div_sel_r    <= div_sel_nxt;
      wlen_r       <= wlen_nxt;
      depth_r      <= depth_nxt;
      started_r    <= started_nxt;
      first_time_r <= first_time_nxt;
      last_time_r  <= last_time_nxt;
      beat_count_r <= beat_count_nxt;
      pos_r        <= pos_nxt;
      full_r       <= full_nxt;
      sum_r        <= sum_nxt;
      slot_ptr_r   <= slot_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ts_r       <= ts_nxt;
    tag_r      <= tag_nxt;
    iv_r       <= iv_nxt;
    span_r     <= span_nxt;
    n_r        <= n_nxt;
    rec_r      <= rec_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the beat rate monitor: beat and register stimulus with a predicting scoreboard.
`timescale 1ns / 1ps

import bra_pkg::*;

class rate_book;
  localparam int WIN_MAX = WINDOW_MAX_DEF;
  localparam logic [63:0] IV_MAX = (64'd1 << INTERVAL_BITS_DEF) - 64'd1;

  logic [WLEN_W-1:0] wlen;
  logic [SLOT_W-1:0] depth;
  bit                started;
  logic [63:0]       first_ts;
  logic [63:0]       last_ts;
  logic [BEAT_W-1:0] beats;
  logic [INTERVAL_BITS_DEF-1:0] iv_win [WIN_MAX];
  int unsigned       win_pos;
  bit                win_full;
  logic [63:0]       iv_sum;
  int unsigned       slot_ptr;

  out_item_t   due_records [$];
  int unsigned mismatches;
  int unsigned records_seen;

  function new();
    wlen = WLEN_RESET;
    depth = DEPTH_RESET;
    started = 0;
    first_ts = '0;
    last_ts = '0;
    beats = '0;
    win_pos = 0;
    win_full = 0;
    iv_sum = '0;
    slot_ptr = 0;
    mismatches = 0;
    records_seen = 0;
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_WINDOW_LENGTH) begin
      wlen = val[WLEN_W-1:0];
      win_pos = 0;
      win_full = 0;
      iv_sum = '0;
    end else if (idx == REG_LOG_DEPTH) begin
      depth = val;
    end
  endfunction

  // Q32.16 of m * 1e9 / den, clamped to the rate width.
  function logic [RATE_W-1:0] rate_of(logic [63:0] m, logic [63:0] den, inout bit sat);
    logic [127:0] num;
    logic [127:0] q;
    num = (128'(m) * 128'(NS_PER_S)) << RATE_FRAC_W;
    q = num / 128'(den);
    if (q > 128'(RATE_MAX)) begin
      sat = 1;
      return RATE_MAX;
    end
    return q[RATE_W-1:0];
  endfunction

  function void note_beat(in_item_t b);
    out_item_t   r;
    logic [63:0] ts;
    logic [63:0] iv;
    logic [63:0] span;
    logic [63:0] n;
    int unsigned len;
    int unsigned depth_eff;
    int unsigned slot;
    bit          sat;
    r = '0;
    sat = 0;
    ts = 64'(b.timestamp);
    depth_eff = (depth == 0) ? 1 : int'(depth);
    len = (wlen == 0) ? 1 : int'(wlen);
    if (len > WIN_MAX) len = WIN_MAX;
    slot = (slot_ptr >= depth_eff) ? 0 : slot_ptr;
    if (!started) begin
      started = 1;
      first_ts = ts;
      last_ts = ts;
    end else begin
      if (ts <= last_ts) begin
        iv = 64'd1;
        sat = 1;
      end else begin
        iv = ts - last_ts;
        if (iv > IV_MAX) begin
          iv = IV_MAX;
          sat = 1;
        end
      end
      last_ts = ts;
      if (win_pos >= len) begin
        win_pos = 0;
        win_full = 1;
      end
      // drop the oldest interval once the window is full
      if (win_full) iv_sum = iv_sum - 64'(iv_win[win_pos]);
      iv_sum = iv_sum + iv;
      iv_win[win_pos] = iv[INTERVAL_BITS_DEF-1:0];
      n = win_full ? 64'(len) : 64'(win_pos + 1);
      win_pos++;
      if (win_pos >= len) begin
        win_pos = 0;
        win_full = 1;
      end
      if (ts <= first_ts) begin
        span = 64'd1;
        sat = 1;
      end else begin
        span = ts - first_ts;
      end
      r.last_rate = rate_of(64'd1, iv, sat);
      r.mean_rate = rate_of(n, (iv_sum == 0) ? 64'd1 : iv_sum, sat);
      r.total_rate = rate_of(64'(beats) + 64'd1, span, sat);
    end
    r.beat_number = beats;
    r.tag_out = b.tag;
    r.beat_time = b.timestamp;
    r.log_slot = slot[SLOT_W-1:0];
    r.saturated = sat;
    due_records.push_back(r);
    if (beats < BEAT_MAX) beats++;
    slot++;
    slot_ptr = (slot >= depth_eff) ? 0 : slot;
  endfunction

  function void report(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("record %0d %s: expected %0h, got %0h", records_seen, what, want, got);
  endfunction

  function void check_record(out_item_t got);
    out_item_t want;
    records_seen++;
    if (due_records.size() == 0) begin
      report("unexpected, beat_time", 64'd0, 64'(got.beat_time));
      return;
    end
    want = due_records.pop_front();
    if (got.beat_number !== want.beat_number)
      report("beat_number", 64'(want.beat_number), 64'(got.beat_number));
    if (got.tag_out !== want.tag_out)
      report("tag_out", 64'(unsigned'(want.tag_out)), 64'(unsigned'(got.tag_out)));
    if (got.beat_time !== want.beat_time)
      report("beat_time", 64'(want.beat_time), 64'(got.beat_time));
    if (got.log_slot !== want.log_slot)
      report("log_slot", 64'(want.log_slot), 64'(got.log_slot));
    if (got.last_rate !== want.last_rate)
      report("last_rate", 64'(want.last_rate), 64'(got.last_rate));
    if (got.mean_rate !== want.mean_rate)
      report("mean_rate", 64'(want.mean_rate), 64'(got.mean_rate));
    if (got.total_rate !== want.total_rate)
      report("total_rate", 64'(want.total_rate), 64'(got.total_rate));
    if (got.saturated !== want.saturated)
      report("saturated", 64'(want.saturated), 64'(got.saturated));
  endfunction
endclass

module tb_top;
  localparam logic [63:0] TS_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int SEGMENTS = 6;
  localparam int SEG_BEATS = 225;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rate_book    book = new();
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 87;
  int unsigned stall_left = 0;
  logic [62:0] last_ts = '0;

  beat_rate_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Result side: check each accepted word, then pick next cycle's ready.
  always @(posedge clk) begin
    if (out_valid && out_ready) book.check_record(out_data);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(199) == 0) begin
      stall_left <= $urandom_range(1, 400);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input logic [62:0] ts, input logic [31:0] tag);
    in_item_t    b;
    int unsigned gap;
    b.timestamp = ts;
    b.tag = tag;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 330);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    last_ts = ts;
    book.note_beat(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    book.apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.due_records.size() != 0) @(posedge clk);
  endtask

  // Mostly forward steps of every scale; the rest exercise the clamps.
  function automatic logic [62:0] pick_ts();
    int unsigned pick;
    logic [63:0] step;
    logic [63:0] base;
    logic [63:0] wide;
    pick = $urandom_range(99);
    base = 64'(last_ts);
    wide = {$urandom, $urandom};
    if (pick < 60) begin
      step = (64'($urandom) >> $urandom_range(31)) + 64'd1;
    end else if (pick < 70) begin
      step = wide & 64'h3FF_FFFF_FFFF;
    end else if (pick < 78) begin
      return last_ts;
    end else if (pick < 86) begin
      step = 64'($urandom_range(1, 1000000));
      return (base >= step) ? 63'(base - step) : 63'd0;
    end else if (pick < 92) begin
      return 63'(wide);
    end else if (pick < 96) begin
      return 63'(wide % (book.first_ts + 64'd1));
    end else begin
      return 63'(TS_TOP - 64'($urandom_range(0, 1000)));
    end
    if (base + step > TS_TOP) return 63'(wide);
    return 63'(base + step);
  endfunction

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [62:0]           ts;
    logic [CFG_DATA_W-1:0] wl_val;
    logic [CFG_DATA_W-1:0] dp_val;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset register values.
    send_beat(63'd1000, 32'h0000_0000);
    send_beat(63'd1000, 32'hFFFF_FFFF);
    send_beat(63'd999, 32'h8000_0000);
    send_beat(63'd1001, 32'h7FFF_FFFF);
    send_beat(63'd1001 + (63'd1 << INTERVAL_BITS_DEF), $urandom);
    send_beat(last_ts + ((63'd1 << INTERVAL_BITS_DEF) - 63'd1), $urandom);
    send_beat(last_ts + 63'd1, $urandom);
    send_beat(last_ts + 63'd1, $urandom);
    send_beat(last_ts + 63'd2, $urandom);
    send_beat(63'(TS_TOP), 32'h5555_5555);
    send_beat(63'd0, 32'hAAAA_AAAA);
    for (int i = 0; i < 10; i++) send_beat(last_ts + 63'd1000000, $urandom);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 19;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: begin
          wl_val = 16'd1;
          dp_val = 16'd1;
        end
        1: begin
          wl_val = 16'd64;
          dp_val = 16'd65535;
        end
        2: begin
          wl_val = 16'hFF00;
          dp_val = 16'd0;
        end
        3: begin
          wl_val = 16'h007F;
          dp_val = 16'd3;
        end
        4: begin
          wl_val = {9'($urandom), 7'($urandom_range(1, 64))};
          dp_val = 16'($urandom_range(1, 65535));
        end
        default: begin
          wl_val = 16'd65;
          dp_val = 16'd2;
        end
      endcase
      write_reg(REG_WINDOW_LENGTH, wl_val);
      write_reg(REG_LOG_DEPTH, dp_val);
      for (int i = 0; i < SEG_BEATS; i++) begin
        ts = pick_ts();
        send_beat(ts, $urandom);
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (book.mismatches == 0 && book.due_records.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bra_pkg.sv
rtl/bra_ram.sv
rtl/bra_div.sv
rtl/beat_rate_monitor.sv
sim/tb_top.sv
